// ----- rtl/core/csq_pkg.sv -----
// Shared types and constants for the class selective ticket queue.
`default_nettype none
package csq_pkg;

  localparam int TicketW = 16;
  localparam int ClassW  = 2;

  localparam logic [ClassW-1:0] CLASS_INVALID = 2'd3;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_FULL     = 3'd1,
    ST_INVALID  = 3'd2,
    ST_SERVED   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH,
    OP_SCAN_START,
    OP_SCAN,
    OP_REMOVE
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t            op;
    logic                head;
    logic [ClassW-1:0]   cls;
    logic [TicketW-1:0]  tkt;
    logic [ClassW-1:0]   want;
  } cell_ctrl_t;

  typedef struct packed {
    logic                valid;
    logic [ClassW-1:0]   cls;
    logic [TicketW-1:0]  tkt;
  } entry_t;

  // Per-cell scan status seen by the controller.
  typedef struct packed {
    logic token;
    logic hit;
    logic empty_tok;
    logic pass;
  } cell_stat_t;

  typedef struct packed {
    status_t             status;
    logic                matched;
    logic [ClassW-1:0]   cls;
    logic [TicketW-1:0]  tkt;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/class_selective_ticket_queue_core.sv -----
// Top level of the class selective ticket queue: controller, cell chain and result buffer.
//
//  Channel  Direction  Handshake                  Payload
//  s_*      in         s_tvalid / s_tready        s_tuser: mode; s_tdata: ticket_class, server_id
//  m_*      out        m_tvalid / m_tready        m_tuser: status; m_tdata: ticket, class, match
//  cfg_*    in         cfg_valid / cfg_ready      cfg_data: server_class_map
//
// An enqueue item's result is loaded at the edge that accepts it, into the output register
// or, while that is held, into the spare, and the next item can be taken in the following
// cycle unless the spare is in use. A serve item walks a search token down the cell chain
// one cell per cycle from the head; the first entry of the wanted class is served, and the
// head is served as a fallback when the token reaches an empty cell, or passes the last
// cell of a full queue. Reset clears all valid bits, sets the ticket counter to one and
// the class map to 129. A result that cannot leave goes into a spare register; input is
// held off while a serve is scanning and while that spare is in use.
`default_nettype none
module class_selective_ticket_queue_core
  import csq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [1:0] ticket_class, [3:2] server_id
  input  wire logic [0:0]  s_tuser,   // [0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [15:0] ticket_number, [17:16] served_class,
                                      // [18] class_matched
  output logic [2:0]       m_tuser,   // [2:0] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data   // [7:0] server_class_map
);

  state_t state, state_next;

  logic [7:0]         class_map;
  logic [ClassW-1:0]  want;
  logic [TicketW-1:0] next_ticket;

  logic               s_fire;
  logic               mode;
  logic [ClassW-1:0]  in_cls;
  logic [1:0]         in_srv;

  cell_ctrl_t ctrl;
  entry_t     entries  [QUEUE_DEPTH];
  cell_stat_t stats    [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] tokens;
  logic [QUEUE_DEPTH-1:0] hits;

  logic    hit_any;
  logic    end_any;
  entry_t  pick;
  logic    queue_full;
  logic    queue_empty;

  logic    res_valid;
  result_t res;
  logic    spare_full;
  result_t out_data;

  assign s_fire = s_tvalid && s_tready;
  assign mode   = s_tuser[0];
  assign in_cls = s_tdata[1:0];
  assign in_srv = s_tdata[3:2];

  assign queue_full  = entries[QUEUE_DEPTH-1].valid;
  assign queue_empty = !entries[0].valid;

  // Input is taken only between serves and while the spare result slot is free.
  assign s_tready  = (state == S_IDLE) && !spare_full;
  assign cfg_ready = 1'b1;

  // The cell chain. Each cell sees its neighbors only: the one ahead for the tail
  // position and the token, the one behind for closing up after a removal.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nxt;
    logic   pv;
    logic   pp;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = entries[i+1];
    end
    if (i == 0) begin : g_head
      assign pv = 1'b1;
      assign pp = 1'b0;
    end else begin : g_tail
      assign pv = entries[i-1].valid;
      assign pp = stats[i-1].pass;
    end

    csq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .is_head    ((i == 0)),
      .prev_valid (pv),
      .prev_pass  (pp),
      .next_entry (nxt),
      .entry      (entries[i]),
      .stat       (stats[i])
    );

    assign tokens[i] = stats[i].token;
    assign hits[i]   = stats[i].hit;
  end

  // At most one cell holds the token, so the hit entry is gathered with a plain OR.
  always_comb begin
    pick    = '0;
    end_any = stats[QUEUE_DEPTH-1].pass;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (hits[i]) pick = pick | entries[i];
      end_any = end_any | stats[i].empty_tok;
    end
  end

  assign hit_any = |hits;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      class_map   <= 8'd129;
      next_ticket <= TicketW'(1);
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) class_map <= cfg_data;
      if (ctrl.op == OP_PUSH) next_ticket <= next_ticket + TicketW'(1);
    end
  end

  // The wanted class is looked up once, when the serve item is taken.
  always_ff @(posedge clk) begin
    if (s_fire) want <= class_map[{in_srv, 1'b0} +: 2];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_fire && mode && !queue_empty) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (hit_any || end_any) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    ctrl.op   = OP_HOLD;
    ctrl.cls  = in_cls;
    ctrl.tkt  = next_ticket;
    ctrl.want = want;
    res_valid = 1'b0;
    res       = '0;
    res.status = ST_EMPTY;
    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          if (!mode) begin
            res_valid = 1'b1;
            if (queue_full) begin
              res.status = ST_FULL;
            end else if (in_cls == CLASS_INVALID) begin
              res.status = ST_INVALID;
            end else begin
              ctrl.op    = OP_PUSH;
              res.status = ST_ENQUEUED;
              res.tkt    = next_ticket;
              res.cls    = in_cls;
            end
          end else if (queue_empty) begin
            res_valid  = 1'b1;
            res.status = ST_EMPTY;
          end else begin
            ctrl.op = OP_SCAN_START;
          end
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          ctrl.op     = OP_REMOVE;
          ctrl.head   = 1'b0;
          res_valid   = 1'b1;
          res.status  = ST_SERVED;
          res.tkt     = pick.tkt;
          res.cls     = pick.cls;
          res.matched = 1'b1;
        end else if (end_any) begin
          // No entry of the wanted class: serve the head and close up the whole row.
          ctrl.op     = OP_REMOVE;
          ctrl.head   = 1'b1;
          res_valid   = 1'b1;
          res.status  = ST_SERVED;
          res.tkt     = entries[0].tkt;
          res.cls     = entries[0].cls;
          res.matched = 1'b0;
        end else begin
          ctrl.op = OP_SCAN;
        end
      end
      default: begin
      end
    endcase
  end

  csq_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res        (res),
    .spare_full (spare_full),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_data)
  );

  assign m_tuser = out_data.status;
  assign m_tdata = {5'd0, out_data.matched, out_data.cls, out_data.tkt};

  // The search token is never in more than one cell.
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tokens))
    else $error("search token present in more than one cell");

  // A scan always finds a result cell: it is started only on a non-empty queue.
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !queue_empty)
    else $error("scan running on an empty queue");

  // The spare slot is used only behind a held output register.
  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    spare_full |-> m_tvalid)
    else $error("spare result held while output register is empty");

  // A serve that starts a scan puts the token on the head cell.
  a_token_at_head: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_SCAN_START) |=> tokens[0])
    else $error("scan did not start at the head cell");

endmodule
`default_nettype wire

// ----- rtl/core/csq_cell.sv -----
// One queue slot: holds an entry, takes part in the search token walk and closes up on removal.
`default_nettype none
module csq_cell
  import csq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       is_head,
  input  wire logic       prev_valid,
  input  wire logic       prev_pass,
  input  wire entry_t     next_entry,
  output entry_t          entry,
  output cell_stat_t      stat
);

  logic valid;
  logic token;
  logic keep;
  logic [ClassW-1:0]  cls;
  logic [TicketW-1:0] tkt;
  logic match;
  logic do_push;
  logic do_shift;

  assign match    = valid && (cls == ctrl.want);
  assign do_push  = (ctrl.op == OP_PUSH) && !valid && prev_valid;
  assign do_shift = (ctrl.op == OP_REMOVE) && (ctrl.head || !keep);

  assign stat.token     = token;
  assign stat.hit       = token && match;
  assign stat.empty_tok = token && !valid;
  assign stat.pass      = token && valid && !match;

  assign entry.valid = valid;
  assign entry.cls   = cls;
  assign entry.tkt   = tkt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      token <= 1'b0;
      keep  <= 1'b0;
    end else begin
      case (ctrl.op)
        OP_PUSH: begin
          if (do_push) valid <= 1'b1;
        end
        OP_SCAN_START: begin
          token <= is_head;
          keep  <= 1'b0;
        end
        OP_SCAN: begin
          token <= prev_pass;
          if (stat.pass) keep <= 1'b1;
        end
        OP_REMOVE: begin
          token <= 1'b0;
          if (do_shift) valid <= next_entry.valid;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cls <= ctrl.cls;
      tkt <= ctrl.tkt;
    end else if (do_shift) begin
      cls <= next_entry.cls;
      tkt <= next_entry.tkt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/csq_out_skid.sv -----
// Output register with one spare slot so a result never waits on the producer side.
`default_nettype none
module csq_out_skid
  import csq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         spare_full,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    out_free;
  result_t spare;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      spare_full <= 1'b0;
    end else if (out_free) begin
      if (spare_full) begin
        out_valid  <= 1'b1;
        spare_full <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      spare_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (spare_full) out_data <= spare;
      else if (res_valid) out_data <= res;
    end else if (res_valid) begin
      spare <= res;
    end
  end

endmodule
`default_nettype wire
